// ===== sv/station_bin_demand_averager_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the station bin demand averager
// Used by the RTL file that checks its own control logic.
// ----------------------------------------------------------------------------
`ifndef STATION_BIN_DEMAND_AVERAGER_DEFINES_SVH
`define STATION_BIN_DEMAND_AVERAGER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define SBDA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define SBDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sbda_pkg.sv =====
// ----------------------------------------------------------------------------
// sbda_pkg
// Shared constants and types of the station bin demand averager.
// ----------------------------------------------------------------------------
package sbda_pkg;

  localparam int SECS_PER_DAY = 86400;

  localparam int IN_W       = 32;
  localparam int OUT_W      = 56;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int DIV_N_W = 24;
  localparam int DIV_D_W = 18;

  localparam logic [1:0] CMD_ADD     = 2'd0;
  localparam logic [1:0] CMD_PREDICT = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAILY_MEAN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DAILY_VAR  = 2'd2;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quot;
    logic [DIV_D_W-1:0] rem;
  } div_rsp_t;

endpackage

// ===== sv/sbda_div.sv =====
// ----------------------------------------------------------------------------
// sbda_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sbda_div (
  input  logic              clk,
  input  logic              rst_n,
  input  sbda_pkg::div_req_t req,
  output sbda_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(sbda_pkg::DIV_N_W + 1);

  logic [CNT_W-1:0]             cnt_r;
  logic [sbda_pkg::DIV_N_W-1:0] q_r;
  logic [sbda_pkg::DIV_D_W-1:0] r_r;
  logic [sbda_pkg::DIV_D_W-1:0] d_r;
  logic                         done_r;
  logic [sbda_pkg::DIV_D_W:0]   shifted;
  logic [sbda_pkg::DIV_D_W:0]   trial;

  assign shifted = {r_r, q_r[sbda_pkg::DIV_N_W-1]};
  assign trial   = shifted - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        q_r   <= req.dividend;
        r_r   <= '0;
        d_r   <= req.divisor;
        cnt_r <= CNT_W'(sbda_pkg::DIV_N_W);
      end else if (cnt_r != '0) begin
        // keep the difference when it does not borrow
        if (!trial[sbda_pkg::DIV_D_W]) begin
          r_r <= trial[sbda_pkg::DIV_D_W-1:0];
          q_r <= {q_r[sbda_pkg::DIV_N_W-2:0], 1'b1};
        end else begin
          r_r <= shifted[sbda_pkg::DIV_D_W-1:0];
          q_r <= {q_r[sbda_pkg::DIV_N_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = r_r;

endmodule

// ===== sv/station_bin_demand_averager.sv =====
// ----------------------------------------------------------------------------
// station_bin_demand_averager
// Booking histogram per station and time-of-day bin with demand prediction.
// ----------------------------------------------------------------------------
// Requests enter on in_tvalid/in_tready/in_tdata: add a booking, predict
// demand, or clear the histogram. Each request yields exactly one result on
// out_tvalid/out_tready/out_tdata. Registers bin width, fallback mean and
// variance are written on cfg_valid/cfg_ready/cfg_index/cfg_data; the user
// must write them only while idle, which the block does not enforce. One
// request is worked at a time. The day split is a six-step compare and
// subtract against shifted copies of the day length; bin and mean share one
// divider. An add splits the day, divides for the bin and writes the entry;
// a predict reads it, sums its day marks and, for a nonempty bin, divides
// for the mean; an out-of-range bin or station ends after the bin division
// and an unknown command goes to the result. in_tready rises with out_tvalid.
// A clear sweeps the whole memory, one entry per cycle, and loads its result
// when the sweep ends. After reset it runs too, with in_tready low.
// A finished result waits in the output register while out_tready is low;
// a new request is still accepted and worked, and stalls only when its own
// result is ready and the register is still full.
// ----------------------------------------------------------------------------
`include "station_bin_demand_averager_defines.svh"

module station_bin_demand_averager #(
  parameter int NUM_STATIONS = 64,
  parameter int NUM_BINS     = 256,
  parameter int MAX_DAYS     = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // cmd[1:0], station[7:2], time_s[29:8], zero fill
  input  logic [sbda_pkg::IN_W-1:0]        in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // mean_q8[23:0], var_q8[47:24], from_history[48], status[49], zero fill
  output logic [sbda_pkg::OUT_W-1:0]       out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sbda_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbda_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int DEPTH  = NUM_STATIONS * NUM_BINS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BIN_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int DIDX_W = (MAX_DAYS > 1) ? $clog2(MAX_DAYS) : 1;
  localparam int DCNT_W = $clog2(MAX_DAYS + 1);
  localparam int WORD_W = 16 + MAX_DAYS;
  localparam int NL     = (MAX_DAYS + 7) / 8;
  localparam int PAD_W  = NL * 8;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DAY, S_DIV_BIN, S_RD, S_RDW,
    S_SUM, S_POP, S_DIV_MEAN, S_FIN
  } state_t;

  state_t                        state_r;
  logic [1:0]                    cmd_r;
  logic [5:0]                    station_r;
  logic [5:0]                    day_r;
  logic [2:0]                    day_step_r;
  logic [21:0]                   split_r;
  logic [ADDR_W-1:0]             addr_r;
  logic [ADDR_W-1:0]             sweep_r;
  logic                          clr_reply_r;
  logic [15:0]                   count_r;
  logic [3:0]                    lane_r [NL];
  logic [DCNT_W-1:0]             days_r;
  logic [23:0]                   res_mean_r;
  logic [23:0]                   res_var_r;
  logic                          res_hist_r;
  logic                          res_status_r;
  logic                          out_valid_r;
  logic [sbda_pkg::OUT_W-1:0]    out_data_r;
  sbda_pkg::div_req_t            div_req_r;
  sbda_pkg::div_rsp_t            div_rsp;

  logic [16:0]                   bin_width_r;
  logic [23:0]                   daily_mean_r;
  logic [23:0]                   daily_var_r;
  logic [16:0]                   w_eff;

  logic [WORD_W-1:0]             mem [DEPTH];
  logic [WORD_W-1:0]             rdata_r;
  logic                          mem_we;
  logic [ADDR_W-1:0]             mem_waddr;
  logic [WORD_W-1:0]             mem_wdata;

  logic [15:0]                   rd_count;
  logic [MAX_DAYS-1:0]           rd_marks;
  logic [PAD_W-1:0]              marks_pad;
  logic [3:0]                    lane_cnt [NL];
  logic [DCNT_W-1:0]             days_sum;
  logic                          in_range;
  logic                          out_free;
  logic [21:0]                   day_sub;
  logic                          day_ge;
  logic [21:0]                   split_nxt;
  logic [DIDX_W-1:0]             didx;
  logic                          div_go;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_width_r  <= 17'd900;
      daily_mean_r <= '0;
      daily_var_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sbda_pkg::CFG_BIN_WIDTH:  bin_width_r  <= cfg_data[16:0];
        sbda_pkg::CFG_DAILY_MEAN: daily_mean_r <= cfg_data;
        sbda_pkg::CFG_DAILY_VAR:  daily_var_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff = (bin_width_r == '0) ? 17'd1 : bin_width_r;

  sbda_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  // day split: one quotient bit per cycle against the shifted day length
  assign day_sub   = 22'(sbda_pkg::SECS_PER_DAY) << day_step_r;
  assign day_ge    = (split_r >= day_sub);
  assign split_nxt = day_ge ? split_r - day_sub : split_r;

  // wrap the day into the bitmap
  always_comb begin
    didx = '0;
    for (int i = 0; i < 64; i++) begin
      if (day_r == 6'(i)) didx = DIDX_W'(i % MAX_DAYS);
    end
  end

  // histogram memory
  assign rd_count = rdata_r[15:0];
  assign rd_marks = rdata_r[WORD_W-1:16];

  always_comb begin
    mem_we    = (state_r == S_CLR) || (state_r == S_RDW && cmd_r == sbda_pkg::CMD_ADD);
    mem_waddr = (state_r == S_CLR) ? sweep_r : addr_r;
    if (state_r == S_CLR) begin
      mem_wdata = '0;
    end else begin
      mem_wdata = {rd_marks | (MAX_DAYS'(1) << didx),
                   (rd_count == 16'hFFFF) ? rd_count : rd_count + 16'd1};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[addr_r];
  end

  // day count: per-byte popcount, then a short sum over the bytes
  assign marks_pad = PAD_W'(rd_marks);

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      lane_cnt[i] = '0;
      for (int b = 0; b < 8; b++) begin
        lane_cnt[i] = lane_cnt[i] + 4'(marks_pad[i*8+b]);
      end
    end
  end

  always_comb begin
    days_sum = '0;
    for (int i = 0; i < NL; i++) begin
      days_sum = days_sum + DCNT_W'(lane_r[i]);
    end
  end

  assign in_range = (div_rsp.quot < 24'(NUM_BINS)) && (32'(station_r) < NUM_STATIONS);
  assign out_free = !out_valid_r || out_tready;
  assign div_go   = (state_r == S_DAY && day_step_r == 3'd0) ||
                    (state_r == S_POP && count_r != '0 && days_r != '0);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      sweep_r     <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
      div_req_r   <= '0;
    end else begin
      div_req_r.start <= div_go;
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          if (sweep_r == ADDR_W'(DEPTH - 1)) begin
            sweep_r <= '0;
            state_r <= clr_reply_r ? S_FIN : S_IDLE;
          end else begin
            sweep_r <= sweep_r + ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r        <= in_tdata[1:0];
            station_r    <= in_tdata[7:2];
            res_mean_r   <= '0;
            res_var_r    <= '0;
            res_hist_r   <= 1'b0;
            res_status_r <= 1'b0;
            case (in_tdata[1:0])
              sbda_pkg::CMD_ADD, sbda_pkg::CMD_PREDICT: begin
                split_r    <= in_tdata[29:8];
                day_r      <= '0;
                day_step_r <= 3'd5;
                state_r    <= S_DAY;
              end
              sbda_pkg::CMD_CLEAR: begin
                clr_reply_r <= 1'b1;
                state_r     <= S_CLR;
              end
              default: state_r <= S_FIN;
            endcase
          end
        end
        S_DAY: begin
          day_r[day_step_r] <= day_ge;
          split_r           <= split_nxt;
          day_step_r        <= day_step_r - 3'd1;
          if (day_step_r == 3'd0) begin
            if (cmd_r == sbda_pkg::CMD_ADD) begin
              div_req_r.dividend <= 24'(split_nxt[16:0]);
              div_req_r.divisor  <= 18'(w_eff);
            end else begin
              // round half up: (2*rem + w) / (2*w)
              div_req_r.dividend <= 24'({split_nxt[16:0], 1'b0}) + 24'(w_eff);
              div_req_r.divisor  <= {w_eff, 1'b0};
            end
            state_r <= S_DIV_BIN;
          end
        end
        S_DIV_BIN: begin
          if (div_rsp.done) begin
            if (in_range) begin
              addr_r  <= ADDR_W'(int'(station_r) * NUM_BINS
                                 + int'(div_rsp.quot[BIN_W-1:0]));
              state_r <= S_RD;
            end else begin
              if (cmd_r == sbda_pkg::CMD_ADD) begin
                res_status_r <= 1'b1;
              end else begin
                res_mean_r <= daily_mean_r;
                res_var_r  <= daily_var_r;
              end
              state_r <= S_FIN;
            end
          end
        end
        S_RD: state_r <= S_RDW;
        S_RDW: begin
          if (cmd_r == sbda_pkg::CMD_ADD) begin
            state_r <= S_FIN;
          end else begin
            count_r <= rd_count;
            for (int i = 0; i < NL; i++) begin
              lane_r[i] <= lane_cnt[i];
            end
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          days_r  <= days_sum;
          state_r <= S_POP;
        end
        S_POP: begin
          res_var_r <= daily_var_r;
          if (count_r != '0 && days_r != '0) begin
            div_req_r.dividend <= {count_r, 8'd0};
            div_req_r.divisor  <= 18'(days_r);
            state_r            <= S_DIV_MEAN;
          end else begin
            res_mean_r <= daily_mean_r;
            state_r    <= S_FIN;
          end
        end
        S_DIV_MEAN: begin
          if (div_rsp.done) begin
            res_mean_r <= div_rsp.quot;
            res_hist_r <= 1'b1;
            state_r    <= S_FIN;
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (out_free) begin
            out_data_r  <= {6'd0, res_status_r, res_hist_r, res_var_r, res_mean_r};
            clr_reply_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `SBDA_ASSERT_IMPL(a_clr_blocks_in, state_r == S_CLR, !in_tready, "request taken in sweep")
  `SBDA_ASSERT_IMPL(a_we_legal, mem_we, state_r == S_CLR || state_r == S_RDW, "stray write")
  `SBDA_ASSERT_IMPL(a_out_flags, out_tvalid, !(out_tdata[48] && out_tdata[49]), "flag clash")
  `SBDA_ASSERT_NEXT(a_fin_loads, state_r == S_FIN && out_free, out_tvalid && in_tready, "no load")

endmodule
